### rtl/core/zsbf_pkg.sv
// zsbf_pkg: shared types and constants for the zlib stored-block framer
// no dependencies

package zsbf_pkg;

    localparam int unsigned C_RES_DEPTH = 12;
    localparam int unsigned C_RES_CNT_W = 4;

    typedef logic [7:0]             t_byte;
    typedef logic [C_RES_CNT_W-1:0] t_res_cnt;

    localparam t_byte          C_ZHDR_CMF = 8'h78;
    localparam t_byte          C_ZHDR_FLG = 8'h01;
    localparam logic [15:0]    C_MAX_BLOCK = 16'd65535;
    localparam logic [16:0]    C_ADLER_MOD = 17'd65521;
    localparam logic [15:0]    C_ADLER_LOW_INIT = 16'd1;

    localparam logic           C_MODE_DATA = 1'b0;
    localparam logic           C_MODE_EMPTY = 1'b1;

endpackage

### rtl/core/zlib_stored_block_framer_top.sv
// zlib_stored_block_framer_top: wraps a raw byte stream in a zlib stream of stored blocks
// depends on zsbf_pkg
//
// channel   dir  data                      side bits
// s_axis    in   tdata[7:0] data_byte      tuser[0] mode
// m_axis    out  tdata[7:0] out_byte       tlast last_byte
// cfg       in   i_cfg_wdata stream_length i_cfg_we write strobe
//
// an input transfer is held in the input register, then all its output bytes
// (up to 12) are built in one pass into a shift buffer; while m_axis_tready is
// high the buffer drains one byte per cycle and plain data bytes stream at one
// byte per cycle; header, block header and trailer bytes stall the input
// i_rst_n is synchronous, active low; a new stream needs a reset
// m_axis_tready low holds the buffer; one input transfer can wait meanwhile

module zlib_stored_block_framer_top
    import zsbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast
);

    logic [31:0] r_stream_length;
    logic [15:0] r_adler_low;
    logic [15:0] r_adler_high;
    logic [31:0] r_bytes_taken;
    logic [15:0] r_block_left;
    logic        r_header_done;

    logic        r_in_valid;
    logic        r_in_mode;
    t_byte       r_in_byte;

    t_byte       r_buf  [C_RES_DEPTH];
    logic        r_last [C_RES_DEPTH];
    t_res_cnt    r_cnt;

    t_byte       n_buf  [C_RES_DEPTH];
    logic        n_last [C_RES_DEPTH];
    t_res_cnt    n_cnt;
    logic [15:0] n_adler_low;
    logic [15:0] n_adler_high;
    logic [31:0] n_bytes_taken;
    logic [15:0] n_block_left;
    logic        n_header_done;

    logic        move;
    logic        out_xfer;

    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign move          = r_in_valid
                           && ((r_cnt == '0) || ((r_cnt == t_res_cnt'(1)) && m_axis_tready));
    assign s_axis_tready = !r_in_valid || move;

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_buf[0];
    assign m_axis_tlast  = r_last[0];

    always_comb begin
        logic [16:0] low_sum;
        logic [15:0] low_red;
        logic [16:0] high_sum;
        logic [15:0] high_red;
        logic [31:0] remain;
        logic [31:0] taken_inc;
        logic [15:0] blen;
        logic [15:0] blen_inv;
        logic        fin;
        logic [15:0] trl_low;
        logic [15:0] trl_high;
        t_res_cnt    idx;

        low_sum   = {1'b0, r_adler_low} + {9'd0, r_in_byte};
        low_red   = (low_sum >= C_ADLER_MOD) ? 16'(low_sum - C_ADLER_MOD) : low_sum[15:0];
        high_sum  = {1'b0, r_adler_high} + {1'b0, low_red};
        high_red  = (high_sum >= C_ADLER_MOD) ? 16'(high_sum - C_ADLER_MOD)
                                               : high_sum[15:0];
        remain    = r_stream_length - r_bytes_taken;
        taken_inc = r_bytes_taken + 32'd1;
        fin       = (remain[31:16] == '0) && (remain[15:0] <= C_MAX_BLOCK);
        blen      = fin ? remain[15:0] : C_MAX_BLOCK;
        blen_inv  = ~blen;
        trl_low   = r_adler_low;
        trl_high  = r_adler_high;
        idx       = '0;

        for (int i = 0; i < C_RES_DEPTH; i++) begin
            n_buf[i]  = '0;
            n_last[i] = 1'b0;
        end
        n_adler_low   = r_adler_low;
        n_adler_high  = r_adler_high;
        n_bytes_taken = r_bytes_taken;
        n_block_left  = r_block_left;
        n_header_done = r_header_done;

        if (r_in_mode == C_MODE_EMPTY) begin
            if ((r_stream_length == '0) && !r_header_done) begin
                n_header_done = 1'b1;
                n_buf[0]  = C_ZHDR_CMF;
                n_buf[1]  = C_ZHDR_FLG;
                n_buf[2]  = 8'h01;
                n_buf[3]  = 8'h00;
                n_buf[4]  = 8'h00;
                n_buf[5]  = 8'hFF;
                n_buf[6]  = 8'hFF;
                n_buf[7]  = r_adler_high[15:8];
                n_buf[8]  = r_adler_high[7:0];
                n_buf[9]  = r_adler_low[15:8];
                n_buf[10] = r_adler_low[7:0];
                n_last[10] = 1'b1;
                idx = t_res_cnt'(11);
            end
        end else if (r_bytes_taken < r_stream_length) begin
            if (!r_header_done) begin
                n_header_done = 1'b1;
                n_buf[idx] = C_ZHDR_CMF;
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = C_ZHDR_FLG;
                idx = idx + t_res_cnt'(1);
            end
            if (r_block_left == '0) begin
                n_buf[idx] = {7'd0, fin};
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = blen[7:0];
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = blen[15:8];
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = blen_inv[7:0];
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = blen_inv[15:8];
                idx = idx + t_res_cnt'(1);
                n_block_left = blen - 16'd1;
            end else begin
                n_block_left = r_block_left - 16'd1;
            end
            n_buf[idx] = r_in_byte;
            idx = idx + t_res_cnt'(1);
            n_adler_low   = low_red;
            n_adler_high  = high_red;
            n_bytes_taken = taken_inc;
            if (taken_inc == r_stream_length) begin
                n_block_left = '0;
                trl_low  = low_red;
                trl_high = high_red;
                n_buf[idx] = trl_high[15:8];
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = trl_high[7:0];
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = trl_low[15:8];
                idx = idx + t_res_cnt'(1);
                n_buf[idx] = trl_low[7:0];
                n_last[idx] = 1'b1;
                idx = idx + t_res_cnt'(1);
            end
        end
        n_cnt = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= '0;
            r_adler_low     <= C_ADLER_LOW_INIT;
            r_adler_high    <= '0;
            r_bytes_taken   <= '0;
            r_block_left    <= '0;
            r_header_done   <= 1'b0;
            r_in_valid      <= 1'b0;
            r_cnt           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_stream_length <= i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_adler_low   <= n_adler_low;
                r_adler_high  <= n_adler_high;
                r_bytes_taken <= n_bytes_taken;
                r_block_left  <= n_block_left;
                r_header_done <= n_header_done;
                r_cnt         <= n_cnt;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - t_res_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
        if (move) begin
            for (int i = 0; i < C_RES_DEPTH; i++) begin
                r_buf[i]  <= n_buf[i];
                r_last[i] <= n_last[i];
            end
        end else if (out_xfer) begin
            for (int i = 0; i < C_RES_DEPTH - 1; i++) begin
                r_buf[i]  <= r_buf[i+1];
                r_last[i] <= r_last[i+1];
            end
            r_buf[C_RES_DEPTH-1]  <= '0;
            r_last[C_RES_DEPTH-1] <= 1'b0;
        end
    end

endmodule
